>>> hw/rtl/crp_pkg.sv
// Package for the copy-chain position resolver: default sizes, command and
// status codes, and the control/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package crp_pkg;

	// Default sizes
	localparam int MAX_BASE_DEF = 4096;
	localparam int MAX_OPS_DEF  = 64;
	localparam int POS_BITS_DEF = 60;

	// Request commands
	typedef enum logic [1:0] {
		CMD_CHAR  = 2'd0,
		CMD_COPY  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_REJECT = 2'd1,
		ST_BEYOND = 2'd2
	} status_t;

	// Controller to datapath strobes
	typedef struct packed {
		logic    capture;
		logic    chr_write;
		logic    copy_diff;
		logic    copy_sum;
		logic    copy_write;
		logic    clear;
		logic    q_init;
		logic    q_sub;
		logic    q_add;
		logic    q_dec;
		logic    res_load;
		status_t res_status;
		logic    res_char;
		logic    out_load;
	} ctl_t;

	// Datapath to controller flags
	typedef struct packed {
		logic chr_bad;
		logic copy_bad;
		logic pos_ge_total;
		logic pos_lt_base;
		logic ge;
	} stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/crp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module crp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> hw/rtl/crp_datapath.sv
// Datapath of the copy-chain position resolver: length counters, base text
// and copy tables (crp_ram), the position walk arithmetic and result registers.
// Depends on crp_pkg and crp_ram.
`default_nettype none

module crp_datapath #(
	parameter int MAX_BASE = crp_pkg::MAX_BASE_DEF,
	parameter int MAX_OPS  = crp_pkg::MAX_OPS_DEF,
	parameter int POS_BITS = crp_pkg::POS_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire crp_pkg::ctl_t       ctl,
	output crp_pkg::stat_t           stat,
	input  wire logic [7:0]          char_value,
	input  wire logic [POS_BITS-1:0] copy_start,
	input  wire logic [POS_BITS-1:0] copy_end,
	input  wire logic [POS_BITS-1:0] position,
	output logic      [1:0]          status,
	output logic      [7:0]          char_out
);
	import crp_pkg::*;

	localparam int BASE_AW = (MAX_BASE > 1) ? $clog2(MAX_BASE) : 1;
	localparam int BASE_CW = $clog2(MAX_BASE + 1);
	localparam int OP_AW   = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
	localparam int OP_CW   = $clog2(MAX_OPS + 1);
	localparam int CMP_W   = (POS_BITS > BASE_CW) ? POS_BITS : BASE_CW;

	// Captured request
	logic [7:0]          lit_q;
	logic [POS_BITS-1:0] s_q;
	logic [POS_BITS-1:0] e_q;
	logic [POS_BITS-1:0] pos_q;

	// Copy checks
	logic [POS_BITS-1:0] d_q;
	logic                borrow_q;
	logic                e_gt_q;
	logic [POS_BITS:0]   sum_q;

	// Walk state
	logic [POS_BITS-1:0] diff_q;
	logic                ge_q;
	logic [OP_AW-1:0]    idx_q;

	// Store occupancy
	logic [BASE_CW-1:0]  base_len_q;
	logic [OP_CW-1:0]    op_cnt_q;
	logic [POS_BITS-1:0] total_q;

	// Results
	status_t             res_status_q;
	logic [7:0]          res_char_q;
	logic [1:0]          status_q;
	logic [7:0]          char_out_q;

	// RAM read data
	logic [7:0]          base_rdata;
	logic [POS_BITS-1:0] src_rdata;
	logic [POS_BITS-1:0] end_rdata;

	logic [POS_BITS:0]   copy_d;
	logic [POS_BITS:0]   walk_d;
	logic [POS_BITS-1:0] prev_end;
	logic [OP_CW-1:0]    op_last;
	logic                op_full;

	// Tables
	crp_ram #(.WIDTH(8), .DEPTH(MAX_BASE)) u_base_ram (
		.clk   (clk),
		.we    (ctl.chr_write),
		.waddr (base_len_q[BASE_AW-1:0]),
		.wdata (lit_q),
		.raddr (BASE_AW'(pos_q)),
		.rdata (base_rdata)
	);

	crp_ram #(.WIDTH(POS_BITS), .DEPTH(MAX_OPS)) u_src_ram (
		.clk   (clk),
		.we    (ctl.copy_write),
		.waddr (op_cnt_q[OP_AW-1:0]),
		.wdata (s_q),
		.raddr (idx_q),
		.rdata (src_rdata)
	);

	// Holds the text end of each copy; read one entry below the walk index
	crp_ram #(.WIDTH(POS_BITS), .DEPTH(MAX_OPS)) u_end_ram (
		.clk   (clk),
		.we    (ctl.copy_write),
		.waddr (op_cnt_q[OP_AW-1:0]),
		.wdata (sum_q[POS_BITS-1:0]),
		.raddr (idx_q - OP_AW'(1)),
		.rdata (end_rdata)
	);

	// Arithmetic
	assign copy_d   = {1'b0, e_q} - {1'b0, s_q};
	assign prev_end = (idx_q == '0) ? POS_BITS'(base_len_q) : end_rdata;
	assign walk_d   = {1'b0, pos_q} - {1'b0, prev_end};
	assign op_last  = op_cnt_q - OP_CW'(1);
	assign op_full  = (op_cnt_q == OP_CW'(MAX_OPS));

	// Flags to the controller
	always_comb begin
		stat.chr_bad      = (op_cnt_q != '0) || (base_len_q == BASE_CW'(MAX_BASE)) || (&total_q);
		stat.copy_bad     = borrow_q || (d_q == '0) || e_gt_q || sum_q[POS_BITS] || op_full;
		stat.pos_ge_total = (pos_q >= total_q);
		stat.pos_lt_base  = (CMP_W'(pos_q) < CMP_W'(base_len_q));
		stat.ge           = ge_q;
	end

	// Occupancy counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_len_q <= '0;
			op_cnt_q   <= '0;
			total_q    <= '0;
		end else if (ctl.clear) begin
			base_len_q <= '0;
			op_cnt_q   <= '0;
			total_q    <= '0;
		end else if (ctl.chr_write) begin
			base_len_q <= base_len_q + BASE_CW'(1);
			total_q    <= total_q + POS_BITS'(1);
		end else if (ctl.copy_write) begin
			op_cnt_q <= op_cnt_q + OP_CW'(1);
			total_q  <= sum_q[POS_BITS-1:0];
		end
	end

	// Request capture, copy checks and position walk
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			lit_q <= char_value;
			s_q   <= copy_start;
			e_q   <= copy_end;
			pos_q <= position;
		end else if (ctl.q_add) begin
			pos_q <= src_rdata + diff_q;
		end
		if (ctl.copy_diff) begin
			d_q      <= copy_d[POS_BITS-1:0];
			borrow_q <= copy_d[POS_BITS];
		end
		if (ctl.copy_sum) begin
			sum_q  <= {1'b0, total_q} + {1'b0, d_q};
			e_gt_q <= (e_q > total_q);
		end
		if (ctl.q_sub) begin
			diff_q <= walk_d[POS_BITS-1:0];
			ge_q   <= !walk_d[POS_BITS];
		end
		if (ctl.q_init) begin
			idx_q <= op_last[OP_AW-1:0];
		end else if (ctl.q_dec) begin
			idx_q <= idx_q - OP_AW'(1);
		end
		if (ctl.res_load) begin
			res_status_q <= ctl.res_status;
			res_char_q   <= ctl.res_char ? base_rdata : 8'h00;
		end
		if (ctl.out_load) begin
			status_q   <= res_status_q;
			char_out_q <= res_char_q;
		end
	end

	assign status   = status_q;
	assign char_out = char_out_q;

	// A hop only when the covering copy was found
	a_hop_found: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.q_add |-> ge_q)
		else $error("hop taken without a covering copy");

	// Every hop moves the position strictly earlier
	a_hop_back: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.q_add |=> (pos_q < $past(pos_q)))
		else $error("hop did not move position back");

	// The walk never steps below the first copy
	a_idx_floor: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.q_dec |-> (idx_q != '0))
		else $error("copy index underflow");

	// Base characters only before any copy, and tables never overfill
	a_chr_order: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.chr_write |-> (op_cnt_q == '0) && (base_len_q < BASE_CW'(MAX_BASE)))
		else $error("base character written out of order");

	a_op_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.copy_write |-> !op_full)
		else $error("copy table overfilled");

endmodule

`default_nettype wire

>>> hw/rtl/crp_ctrl.sv
// Controller of the copy-chain position resolver: request handshake, command
// sequencing and the output valid flag. Depends on crp_pkg.
`default_nettype none

module crp_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [1:0]     cmd,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire crp_pkg::stat_t stat,
	output crp_pkg::ctl_t       ctl
);
	import crp_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHR,
		S_CD,
		S_CS,
		S_CW,
		S_CLR,
		S_QCHK,
		S_QRD,
		S_QSUB,
		S_QADD,
		S_QCHB,
		S_BRD,
		S_BRES,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Next state and datapath strobes
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					ctl.capture = 1'b1;
					unique case (cmd_t'(cmd))
						CMD_CHAR:  state_d = S_CHR;
						CMD_COPY:  state_d = S_CD;
						CMD_QUERY: state_d = S_QCHK;
						CMD_CLEAR: state_d = S_CLR;
						default:   state_d = S_CLR;
					endcase
				end
			end
			S_CHR: begin
				ctl.res_load = 1'b1;
				if (stat.chr_bad) begin
					ctl.res_status = ST_REJECT;
				end else begin
					ctl.chr_write  = 1'b1;
					ctl.res_status = ST_OK;
				end
				state_d = S_DONE;
			end
			S_CD: begin
				ctl.copy_diff = 1'b1;
				state_d       = S_CS;
			end
			S_CS: begin
				ctl.copy_sum = 1'b1;
				state_d      = S_CW;
			end
			S_CW: begin
				ctl.res_load = 1'b1;
				if (stat.copy_bad) begin
					ctl.res_status = ST_REJECT;
				end else begin
					ctl.copy_write = 1'b1;
					ctl.res_status = ST_OK;
				end
				state_d = S_DONE;
			end
			S_CLR: begin
				ctl.clear      = 1'b1;
				ctl.res_load   = 1'b1;
				ctl.res_status = ST_OK;
				state_d        = S_DONE;
			end
			S_QCHK: begin
				priority if (stat.pos_ge_total) begin
					ctl.res_load   = 1'b1;
					ctl.res_status = ST_BEYOND;
					state_d        = S_DONE;
				end else if (stat.pos_lt_base) begin
					state_d = S_BRD;
				end else begin
					ctl.q_init = 1'b1;
					state_d    = S_QRD;
				end
			end
			// Table address settles; read data registered at this edge
			S_QRD: state_d = S_QSUB;
			S_QSUB: begin
				ctl.q_sub = 1'b1;
				state_d   = S_QADD;
			end
			S_QADD: begin
				if (stat.ge) begin
					ctl.q_add = 1'b1;
					state_d   = S_QCHB;
				end else begin
					ctl.q_dec = 1'b1;
					state_d   = S_QRD;
				end
			end
			S_QCHB: begin
				if (stat.pos_lt_base) begin
					state_d = S_BRD;
				end else begin
					ctl.q_dec = 1'b1;
					state_d   = S_QRD;
				end
			end
			S_BRD: state_d = S_BRES;
			S_BRES: begin
				ctl.res_load   = 1'b1;
				ctl.res_status = ST_OK;
				ctl.res_char   = 1'b1;
				state_d        = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/copy_chain_position_resolver.sv
// Copy-chain position resolver, top level. One request in flight at a time.
// A query past the base text walks the copy table from the newest entry down, hopping
// back into the source of each covering copy. The next request is accepted once the
// previous result has moved to the output register, so no new request is taken while
// one is still being resolved. arst_n clears the counters and control; table contents
// stay undefined.
`default_nettype none

module copy_chain_position_resolver #(
	parameter int MAX_BASE = crp_pkg::MAX_BASE_DEF,
	parameter int MAX_OPS  = crp_pkg::MAX_OPS_DEF,
	parameter int POS_BITS = crp_pkg::POS_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [1:0]          cmd,
	input  wire logic [7:0]          char_value,
	input  wire logic [POS_BITS-1:0] copy_start,
	input  wire logic [POS_BITS-1:0] copy_end,
	input  wire logic [POS_BITS-1:0] position,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic      [1:0]          status,
	output logic      [7:0]          char_out
);
	import crp_pkg::*;

	ctl_t  ctl;
	stat_t stat;

	// Sequencer
	crp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	// Storage and arithmetic
	crp_datapath #(
		.MAX_BASE (MAX_BASE),
		.MAX_OPS  (MAX_OPS),
		.POS_BITS (POS_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.char_value (char_value),
		.copy_start (copy_start),
		.copy_end   (copy_end),
		.position   (position),
		.status     (status),
		.char_out   (char_out)
	);

endmodule

`default_nettype wire

>>> bench/tb_copy_chain_position_resolver.sv
`timescale 1ns / 1ps
// Self-checking bench for copy_chain_position_resolver: directed, doubling-chain
// and random request streams checked against a text predictor.
// Depends on crp_pkg and the copy_chain_position_resolver RTL only.

module tb_copy_chain_position_resolver;
	import crp_pkg::*;

	localparam int MAX_BASE = MAX_BASE_DEF;
	localparam int MAX_OPS = MAX_OPS_DEF;
	localparam int POS_W = POS_BITS_DEF;
	localparam bit [POS_W-1:0] POS_MASK = '1;
	localparam int RANDOM_ITEMS = 1000;
	localparam int LIMIT_CYCLES = 3_000_000;
	localparam int LONG_HOLD = 500;
	localparam int MAX_PRINTS = 100;
	localparam int DRAIN_CYCLES = 4 * MAX_OPS + 8;

	typedef bit [POS_W-1:0] pos_t;

	typedef struct {
		cmd_t     op;
		bit [7:0] ch;
		pos_t     copy_from;
		pos_t     copy_to;
		pos_t     pos;
	} request_t;

	typedef struct {
		status_t  st;
		bit [7:0] ch;
	} answer_t;

	// Text predictor plus queue of answers still owed by the block
	class text_scoreboard;
		bit [7:0] base_chars [MAX_BASE];
		pos_t copy_src [MAX_OPS];
		pos_t copy_stop [MAX_OPS];
		int unsigned n_base;
		int unsigned n_copies;
		pos_t text_len;
		answer_t pending[$];
		int errors;
		int checked;

		function new();
			clear_text();
			errors = 0;
			checked = 0;
		endfunction

		function void clear_text();
			n_base = 0;
			n_copies = 0;
			text_len = '0;
		endfunction

		// Follow copies back until the position falls inside the base text
		function bit walk_back(input pos_t p, output bit [7:0] ch);
			int unsigned hops;
			int unsigned i;
			pos_t seg_start;
			bit hit;
			hops = 0;
			ch = 8'h00;
			while (p >= n_base) begin
				if (hops > MAX_OPS)
					return 1'b0;
				seg_start = n_base;
				hit = 1'b0;
				for (i = 0; i < n_copies; i++) begin
					if (p < copy_stop[i]) begin
						p = copy_src[i] + (p - seg_start);
						hit = 1'b1;
						break;
					end
					seg_start = copy_stop[i];
				end
				if (!hit)
					return 1'b0;
				hops++;
			end
			ch = base_chars[p];
			return 1'b1;
		endfunction

		// Apply an accepted request and queue the answer it must produce
		function void note(request_t r);
			answer_t a;
			bit [7:0] found;
			a.st = ST_OK;
			a.ch = 8'h00;
			case (r.op)
				CMD_CHAR: begin
					if (n_copies != 0 || n_base >= MAX_BASE || text_len >= POS_MASK) begin
						a.st = ST_REJECT;
					end else begin
						base_chars[n_base] = r.ch;
						n_base++;
						text_len++;
					end
				end
				CMD_COPY: begin
					if (r.copy_to <= r.copy_from || r.copy_to > text_len
						|| n_copies >= MAX_OPS
						|| (r.copy_to - r.copy_from) > (POS_MASK - text_len)) begin
						a.st = ST_REJECT;
					end else begin
						text_len += r.copy_to - r.copy_from;
						copy_src[n_copies] = r.copy_from;
						copy_stop[n_copies] = text_len;
						n_copies++;
					end
				end
				CMD_QUERY: begin
					if (r.pos >= text_len || !walk_back(r.pos, found))
						a.st = ST_BEYOND;
					else
						a.ch = found;
				end
				default: clear_text();
			endcase
			pending.push_back(a);
		endfunction

		task report_mismatch(string what);
			if (errors < MAX_PRINTS)
				$display("ERROR: %s", what);
			errors++;
		endtask

		// Compare one accepted result with the oldest owed answer
		task check(logic [1:0] st, logic [7:0] ch);
			answer_t a;
			checked++;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing outstanding", checked));
				return;
			end
			a = pending.pop_front();
			if (st !== a.st)
				report_mismatch($sformatf("result %0d status %0d, expected %0d",
					checked, st, a.st));
			if (ch !== a.ch)
				report_mismatch($sformatf("result %0d char_out %02h, expected %02h",
					checked, ch, a.ch));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	cmd_t req_cmd;
	logic [7:0] req_char;
	logic [POS_W-1:0] req_from;
	logic [POS_W-1:0] req_to;
	logic [POS_W-1:0] req_pos;
	logic out_valid;
	logic out_ready;
	logic [1:0] status;
	logic [7:0] char_out;

	text_scoreboard sb = new();
	int sent_count = 0;

	copy_chain_position_resolver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (req_cmd),
		.char_value(req_char),
		.copy_start(req_from),
		.copy_end  (req_to),
		.position  (req_pos),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.char_out  (char_out)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic pos_t rand_pos();
		bit [63:0] r;
		r = {$urandom, $urandom};
		return r[POS_W-1:0];
	endfunction

	function automatic pos_t pick_below(pos_t n);
		if (n == 0)
			return '0;
		return rand_pos() % n;
	endfunction

	// Offer one request after a random gap and note it once accepted
	task automatic send_request(cmd_t op, bit [7:0] ch, pos_t copy_from, pos_t copy_to,
		pos_t pos);
		int gap;
		request_t r;
		gap = (sent_count % 200 < 40) ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_cmd <= op;
		req_char <= ch;
		req_from <= copy_from;
		req_to <= copy_to;
		req_pos <= pos;
		do @(posedge clk); while (!(in_valid && in_ready));
		r = '{op, ch, copy_from, copy_to, pos};
		sb.note(r);
		sent_count++;
		@(negedge clk);
	endtask

	// Result side: random stalls, one long hold to back the block up
	initial begin
		int gap;
		int got;
		out_ready = 1'b0;
		got = 0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (got == 150)
				gap = LONG_HOLD;
			else if (got % 150 < 30)
				gap = 0;
			else
				gap = $urandom_range(0, 18);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			sb.check(status, char_out);
			got++;
			@(negedge clk);
		end
	end

	// Watchdog
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("copy_chain_position_resolver: mismatch");
		$finish;
	end

	// Stimulus
	initial begin
		int start_count;
		int nb;
		int nc;
		int nq;
		int kind;
		pos_t copy_from;
		pos_t copy_to;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_cmd = CMD_CHAR;
		req_char = '0;
		req_from = '0;
		req_to = '0;
		req_pos = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty text, byte extremes, rejections of late characters and bad copy ranges, chained copies
		send_request(CMD_QUERY, 8'h00, 0, 0, 0);
		send_request(CMD_COPY, 8'h00, 0, 1, 0);
		send_request(CMD_CHAR, 8'h00, 0, 0, 0);
		send_request(CMD_CHAR, 8'hFF, 0, 0, 0);
		send_request(CMD_CHAR, 8'hA5, 0, 0, 0);
		send_request(CMD_CHAR, 8'h5A, 0, 0, 0);
		send_request(CMD_COPY, 8'h00, 2, 2, 0);
		send_request(CMD_COPY, 8'h00, 3, 1, 0);
		send_request(CMD_COPY, 8'h00, 0, 5, 0);
		send_request(CMD_COPY, 8'h00, 1, 4, 0);
		send_request(CMD_CHAR, 8'h33, 0, 0, 0);
		send_request(CMD_QUERY, 8'h00, 0, 0, 0);
		send_request(CMD_QUERY, 8'h00, 0, 0, 3);
		send_request(CMD_QUERY, 8'h00, 0, 0, 4);
		send_request(CMD_QUERY, 8'h00, 0, 0, 6);
		send_request(CMD_QUERY, 8'h00, 0, 0, 7);
		send_request(CMD_QUERY, 8'h00, 0, 0, POS_MASK);
		send_request(CMD_COPY, 8'h00, 4, 7, 0);
		send_request(CMD_QUERY, 8'h00, 0, 0, 9);
		send_request(CMD_COPY, 8'h00, POS_MASK - 1, POS_MASK, 0);
		send_request(CMD_CLEAR, 8'h00, 0, 0, 0);
		send_request(CMD_QUERY, 8'h00, 0, 0, 0);

		// Doubling chain up to the length limit, then fill the copy table
		for (int i = 0; i < 4; i++)
			send_request(CMD_CHAR, 8'($urandom), 0, 0, 0);
		while (sb.text_len <= POS_MASK - sb.text_len)
			send_request(CMD_COPY, 8'h00, 0, sb.text_len, 0);
		send_request(CMD_COPY, 8'h00, 0, sb.text_len, 0);
		send_request(CMD_COPY, 8'h00, 0, POS_MASK, 0);
		while (sb.n_copies < MAX_OPS) begin
			copy_from = sb.text_len - 1 - pick_below(64);
			send_request(CMD_COPY, 8'h00, copy_from, sb.text_len, 0);
		end
		send_request(CMD_COPY, 8'h00, 0, 1, 0);
		send_request(CMD_QUERY, 8'h00, 0, 0, sb.text_len - 1);
		send_request(CMD_QUERY, 8'h00, 0, 0, sb.text_len);
		repeat (30)
			send_request(CMD_QUERY, 8'h00, 0, 0, pick_below(sb.text_len));

		// Random texts: mostly well-formed builds, some broken requests mixed in
		start_count = sent_count;
		while (sent_count - start_count < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 85)
				send_request(CMD_CLEAR, 8'h00, 0, 0, 0);
			nb = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 24);
			repeat (nb) begin
				if ($urandom_range(0, 19) == 0)
					send_request(CMD_QUERY, 8'h00, 0, 0, pick_below(sb.text_len + 2));
				else
					send_request(CMD_CHAR, 8'($urandom), 0, 0, 0);
			end
			nc = ($urandom_range(0, 9) == 0) ? 70 : $urandom_range(0, 12);
			repeat (nc) begin
				kind = $urandom_range(0, 99);
				if (kind < 70) begin
					copy_from = pick_below(sb.text_len);
					copy_to = copy_from + 1 + pick_below(sb.text_len - copy_from);
					send_request(CMD_COPY, 8'h00, copy_from, copy_to, 0);
				end else if (kind < 80) begin
					send_request(CMD_QUERY, 8'h00, 0, 0, pick_below(sb.text_len));
				end else if (kind < 85) begin
					send_request(CMD_COPY, 8'h00, rand_pos(), rand_pos(), 0);
				end else if (kind < 90) begin
					copy_from = pick_below(sb.text_len + 1);
					send_request(CMD_COPY, 8'h00, copy_from, copy_from, 0);
				end else if (kind < 95) begin
					send_request(CMD_COPY, 8'h00, 0, sb.text_len + 1 + pick_below(8), 0);
				end else begin
					send_request(CMD_CHAR, 8'($urandom), 0, 0, 0);
				end
			end
			nq = $urandom_range(3, 15);
			repeat (nq) begin
				kind = $urandom_range(0, 99);
				if (kind < 85)
					send_request(CMD_QUERY, 8'h00, 0, 0, pick_below(sb.text_len));
				else if (kind < 95)
					send_request(CMD_QUERY, 8'h00, 0, 0, sb.text_len + pick_below(4));
				else
					send_request(CMD_QUERY, 8'h00, 0, 0, rand_pos());
			end
		end

		// Drain and decide
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("copy_chain_position_resolver: match");
		else
			$display("copy_chain_position_resolver: mismatch");
		$finish;
	end

endmodule
